>>> src/mow_pkg.sv
// Package for the mecanum wheel odometry block: register indexes, job and
// back-state types shared by the top, front, queue and back modules. No dependencies.
`default_nettype none
package mow_pkg;

	localparam int SUM_W = 35;
	localparam int NUM_W = 128;
	localparam int DEN_W = 114;
	localparam int CFG_IDX_W = 3;
	localparam logic [63:0] TICK_NUM_K = 64'd41156608000000000;
	localparam logic [31:0] TICK_NUM_K_LO = TICK_NUM_K[31:0];
	localparam logic [31:0] TICK_NUM_K_HI = TICK_NUM_K[63:32];
	localparam logic [23:0] SPEED_DEN = 24'd15728640; // 240 * 2^16

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEEL_RADIUS  = 3'd0,
		REG_HALF_LENGTH   = 3'd1,
		REG_HALF_WIDTH    = 3'd2,
		REG_TICKS_PER_REV = 3'd3,
		REG_GEAR_RATIO    = 3'd4
	} reg_idx_t;

	// One classified sample: three speed sums, three tick-delta sums, the
	// elapsed time and a zero-interval flag.
	typedef struct packed {
		logic signed [SUM_W-1:0] sp_x;
		logic signed [SUM_W-1:0] sp_y;
		logic signed [SUM_W-1:0] sp_w;
		logic signed [SUM_W-1:0] tk_x;
		logic signed [SUM_W-1:0] tk_y;
		logic signed [SUM_W-1:0] tk_w;
		logic [63:0] dt;
		logic zero;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_NEXT,
		BK_OUT
	} bk_state_t;

endpackage
`default_nettype wire

>>> src/mecanum_odometry_from_wheels.sv
// Top level of the mecanum wheel odometry block: front, queue, back and
// the configuration registers. Uses mow_pkg and the mow_* modules.
//
// Input channel: in_valid / in_stall carry one wheel sample per transfer.
// Output channel: out_valid / out_stall carry one result per sample.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; ready
// is always high. The user must make writes while the block is idle; the
// block itself does not enforce this. The front part stores the previous
// stamp and tick counts and forms the wheel sums in the cycle of the
// transfer; a two-entry queue holds them. The back part runs six divisions
// on one shared restoring divider, each as multiply phases, then the divide
// loop, then a result step. It takes a new sample from the queue only after
// the result of the last one has been transferred.
// Reset clears the stored stamp and ticks to zero and loads register
// defaults. When the receiver stalls, the result holds; the queue still
// takes up to two more samples before in_stall rises.
`default_nettype none
module mecanum_odometry_from_wheels #(
	parameter int STAMP_BITS = 48,
	parameter int TICK_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [47:0] stamp_ns,
	input  wire logic signed [31:0] speed_fl,
	input  wire logic signed [31:0] speed_fr,
	input  wire logic signed [31:0] speed_rl,
	input  wire logic signed [31:0] speed_rr,
	input  wire logic signed [31:0] ticks_fl,
	input  wire logic signed [31:0] ticks_fr,
	input  wire logic signed [31:0] ticks_rl,
	input  wire logic signed [31:0] ticks_rr,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [31:0] vx_from_speed,
	output logic signed [31:0] vy_from_speed,
	output logic signed [31:0] yaw_from_speed,
	output logic signed [31:0] vx_from_ticks,
	output logic signed [31:0] vy_from_ticks,
	output logic signed [31:0] yaw_from_ticks,
	output logic zero_interval,
	output logic clipped,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [mow_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	logic [15:0] wheel_radius_q, half_length_q, half_width_q, ticks_per_rev_q;
	logic [7:0] gear_ratio_q;
	logic fj_valid, q_full, q_valid, q_take;
	mow_pkg::job_t fj, qj;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q <= 16'd4588;
			half_length_q <= 16'd13107;
			half_width_q <= 16'd11076;
			ticks_per_rev_q <= 16'd42;
			gear_ratio_q <= 8'd5;
		end else if (cfg_valid) begin
			case (cfg_index)
				mow_pkg::REG_WHEEL_RADIUS: wheel_radius_q <= cfg_data;
				mow_pkg::REG_HALF_LENGTH: half_length_q <= cfg_data;
				mow_pkg::REG_HALF_WIDTH: half_width_q <= cfg_data;
				mow_pkg::REG_TICKS_PER_REV: ticks_per_rev_q <= cfg_data;
				mow_pkg::REG_GEAR_RATIO: gear_ratio_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mow_front #(.STAMP_BITS(STAMP_BITS), .TICK_BITS(TICK_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .stamp_ns,
		.speed_fl, .speed_fr, .speed_rl, .speed_rr,
		.ticks_fl, .ticks_fr, .ticks_rl, .ticks_rr,
		.job_valid(fj_valid), .job_full(q_full), .job(fj)
	);

	mow_queue u_queue (
		.clk, .arst_n, .wr_en(fj_valid), .wr_data(fj), .full(q_full),
		.rd_valid(q_valid), .rd_en(q_take), .rd_data(qj)
	);

	mow_back u_back (
		.clk, .arst_n, .job_valid(q_valid), .job_take(q_take), .job(qj),
		.wheel_radius(wheel_radius_q), .half_length(half_length_q),
		.half_width(half_width_q), .ticks_per_rev(ticks_per_rev_q),
		.gear_ratio(gear_ratio_q), .out_valid, .out_stall,
		.vx_from_speed, .vy_from_speed, .yaw_from_speed,
		.vx_from_ticks, .vy_from_ticks, .yaw_from_ticks,
		.zero_interval, .clipped
	);

	// A zero interval always forces zero tick results.
	a_zero_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_interval) |-> (vx_from_ticks == 0 && vy_from_ticks == 0
			&& yaw_from_ticks == 0))
		else $error("tick results nonzero on zero interval");

	// The queue never takes a sample while full.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !fj_valid)
		else $error("queue overflow");

	// The back part only dequeues when the queue has data.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("queue underflow");

endmodule
`default_nettype wire

>>> src/mow_front.sv
// Front part: takes in samples, forms tick deltas and elapsed time against
// the stored previous sample and builds the wheel sums. Uses mow_pkg.
`default_nettype none
module mow_front #(
	parameter int STAMP_BITS = 48,
	parameter int TICK_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [47:0] stamp_ns,
	input  wire logic signed [31:0] speed_fl,
	input  wire logic signed [31:0] speed_fr,
	input  wire logic signed [31:0] speed_rl,
	input  wire logic signed [31:0] speed_rr,
	input  wire logic signed [31:0] ticks_fl,
	input  wire logic signed [31:0] ticks_fr,
	input  wire logic signed [31:0] ticks_rl,
	input  wire logic signed [31:0] ticks_rr,
	output logic job_valid,
	input  wire logic job_full,
	output mow_pkg::job_t job
);

	logic [STAMP_BITS-1:0] last_stamp_q;
	logic [TICK_BITS-1:0] last_ticks_q [4];
	logic [TICK_BITS-1:0] t_now [4];
	logic signed [TICK_BITS-1:0] d [4];
	logic signed [mow_pkg::SUM_W-1:0] s [4];
	logic signed [mow_pkg::SUM_W-1:0] e [4];
	logic [STAMP_BITS-1:0] stamp, dt;
	logic take;

	assign in_stall = job_full;
	assign take = in_valid && !job_full;
	assign job_valid = take;
	assign stamp = STAMP_BITS'({16'd0, stamp_ns});
	assign dt = stamp - last_stamp_q;

	always_comb begin
		t_now[0] = ticks_fl[TICK_BITS-1:0];
		t_now[1] = ticks_fr[TICK_BITS-1:0];
		t_now[2] = ticks_rl[TICK_BITS-1:0];
		t_now[3] = ticks_rr[TICK_BITS-1:0];
		s[0] = mow_pkg::SUM_W'(speed_fl);
		s[1] = mow_pkg::SUM_W'(speed_fr);
		s[2] = mow_pkg::SUM_W'(speed_rl);
		s[3] = mow_pkg::SUM_W'(speed_rr);
		for (int i = 0; i < 4; i++) begin
			d[i] = t_now[i] - last_ticks_q[i];
			e[i] = mow_pkg::SUM_W'(d[i]);
		end
		job.sp_x = s[0] + s[1] + s[2] + s[3];
		job.sp_y = -s[0] + s[1] + s[2] - s[3];
		job.sp_w = -s[0] + s[1] - s[2] + s[3];
		job.tk_x = e[0] + e[1] + e[2] + e[3];
		job.tk_y = -e[0] + e[1] + e[2] - e[3];
		job.tk_w = -e[0] + e[1] - e[2] + e[3];
		job.dt = 64'(dt);
		job.zero = (dt == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			for (int i = 0; i < 4; i++) last_ticks_q[i] <= '0;
		end else if (take) begin
			last_stamp_q <= stamp;
			for (int i = 0; i < 4; i++) last_ticks_q[i] <= t_now[i];
		end
	end

endmodule
`default_nettype wire

>>> src/mow_queue.sv
// Two-entry queue of classified samples between front and back parts.
// Uses mow_pkg for the job type.
`default_nettype none
module mow_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr_en,
	input  wire mow_pkg::job_t wr_data,
	output logic full,
	output logic rd_valid,
	input  wire logic rd_en,
	output mow_pkg::job_t rd_data
);

	mow_pkg::job_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_en) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule
`default_nettype wire

>>> src/mow_back.sv
// Back part: six scaled divisions per sample on one shared restoring
// divider, one quotient bit per cycle. Uses mow_pkg.
`default_nettype none
module mow_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic job_valid,
	output logic job_take,
	input  wire mow_pkg::job_t job,
	input  wire logic [15:0] wheel_radius,
	input  wire logic [15:0] half_length,
	input  wire logic [15:0] half_width,
	input  wire logic [15:0] ticks_per_rev,
	input  wire logic [7:0] gear_ratio,
	output logic out_valid,
	input  wire logic out_stall,
	output logic signed [31:0] vx_from_speed,
	output logic signed [31:0] vy_from_speed,
	output logic signed [31:0] yaw_from_speed,
	output logic signed [31:0] vx_from_ticks,
	output logic signed [31:0] vy_from_ticks,
	output logic signed [31:0] yaw_from_ticks,
	output logic zero_interval,
	output logic clipped
);

	localparam int NW = mow_pkg::NUM_W;
	localparam int DW = mow_pkg::DEN_W;

	mow_pkg::bk_state_t state_q, state_d;
	mow_pkg::job_t job_q;
	logic [2:0] sel_q;
	logic [2:0] mph_q;
	logic [6:0] bit_q;
	logic [NW-1:0] num_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic neg_q;
	logic [50:0] mag_r_q;
	logic [23:0] nt_q;
	logic [49:0] dnt_q;
	logic signed [31:0] res_q [6];
	logic clip_q;

	logic signed [mow_pkg::SUM_W-1:0] sum_sel;
	logic [mow_pkg::SUM_W-1:0] mag;
	logic [16:0] lsum;
	logic [DW:0] rem_sh;
	logic [DW:0] rem_sub;
	logic [31:0] limit;
	logic sat;
	logic [31:0] qv;
	logic skip;

	assign lsum = {1'b0, half_length} + {1'b0, half_width};

	always_comb begin
		case (sel_q)
			3'd0: sum_sel = job_q.sp_x;
			3'd1: sum_sel = job_q.sp_y;
			3'd2: sum_sel = job_q.sp_w;
			3'd3: sum_sel = job_q.tk_x;
			3'd4: sum_sel = job_q.tk_y;
			default: sum_sel = job_q.tk_w;
		endcase
		mag = sum_sel[mow_pkg::SUM_W-1] ? mow_pkg::SUM_W'(-sum_sel) : sum_sel;
		rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		limit = neg_q ? 32'h8000_0000 : 32'h7fff_ffff;
		sat = (quo_q[NW-1:32] != '0) || (quo_q[31:0] > limit);
		qv = sat ? limit : quo_q[31:0];
		skip = (den_q == '0) || (sel_q >= 3'd3 && job_q.zero);
	end

	// Multiply phases build numerator and denominator from partial products
	// of operands no wider than 35 bits, one step a cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			mow_pkg::BK_IDLE: begin
				if (job_valid) job_q <= job;
			end
			mow_pkg::BK_MUL: begin
				case (mph_q)
					3'd0: begin
						neg_q <= sum_sel[mow_pkg::SUM_W-1];
						mag_r_q <= 51'(mag) * 51'(wheel_radius);
						nt_q <= 24'(ticks_per_rev) * 24'(gear_ratio);
					end
					3'd1: begin
						dnt_q <= 50'(nt_q) * 50'(400);
						if (sel_q < 3'd3) num_q <= NW'(mag_r_q);
						else num_q <= NW'(mag_r_q[31:0]) * NW'(mow_pkg::TICK_NUM_K_LO);
					end
					3'd2: begin
						dnt_q <= 50'(dnt_q[32:0]) * 50'(sel_q == 3'd5 ? lsum : 17'd65536);
						if (sel_q >= 3'd3)
							num_q <= num_q + ((NW'(mag_r_q[31:0])
								* NW'(mow_pkg::TICK_NUM_K_HI)) << 32);
					end
					3'd3: begin
						if (sel_q < 3'd3) begin
							if (sel_q == 3'd2) den_q <= DW'(lsum) * DW'(240);
							else den_q <= DW'(mow_pkg::SPEED_DEN);
						end else begin
							den_q <= DW'(job_q.dt[31:0]) * DW'(dnt_q[31:0]);
							num_q <= num_q + ((NW'(mag_r_q[50:32])
								* NW'(mow_pkg::TICK_NUM_K_LO)) << 32);
						end
					end
					3'd4: if (sel_q >= 3'd3) begin
						den_q <= den_q + ((DW'(job_q.dt[63:32]) * DW'(dnt_q[31:0])) << 32);
						num_q <= num_q + ((NW'(mag_r_q[50:32])
							* NW'(mow_pkg::TICK_NUM_K_HI)) << 64);
					end
					3'd5: if (sel_q >= 3'd3) begin
						den_q <= den_q + ((DW'(job_q.dt[31:0]) * DW'(dnt_q[49:32])) << 32);
					end
					3'd6: if (sel_q >= 3'd3) begin
						den_q <= den_q + ((DW'(job_q.dt[63:32]) * DW'(dnt_q[49:32])) << 64);
					end
					default: begin
						num_q <= num_q + NW'(den_q >> 1);
						rem_q <= '0;
						quo_q <= '0;
						bit_q <= 7'd127;
					end
				endcase
			end
			mow_pkg::BK_DIV: begin
				num_q <= num_q << 1;
				if (!rem_sub[DW]) begin
					rem_q <= rem_sub;
					quo_q <= {quo_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					quo_q <= {quo_q[NW-2:0], 1'b0};
				end
				bit_q <= bit_q - 7'd1;
			end
			default: ;
		endcase
		if (state_q == mow_pkg::BK_NEXT)
			res_q[sel_q] <= skip ? 32'sd0 : (neg_q ? -$signed(qv) : $signed(qv));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mow_pkg::BK_IDLE;
			sel_q <= 3'd0;
			mph_q <= 3'd0;
			clip_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mow_pkg::BK_IDLE: begin
					sel_q <= 3'd0;
					mph_q <= 3'd0;
					if (job_valid) clip_q <= 1'b0;
				end
				mow_pkg::BK_MUL: mph_q <= mph_q + 3'd1;
				mow_pkg::BK_NEXT: begin
					if (!skip && sat) clip_q <= 1'b1;
					sel_q <= sel_q + 3'd1;
					mph_q <= 3'd0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		job_take = 1'b0;
		case (state_q)
			mow_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					state_d = mow_pkg::BK_MUL;
				end
			end
			mow_pkg::BK_MUL: if (mph_q == 3'd7) state_d = mow_pkg::BK_DIV;
			mow_pkg::BK_DIV: if (bit_q == 7'd0) state_d = mow_pkg::BK_NEXT;
			mow_pkg::BK_NEXT:
				state_d = (sel_q == 3'd5) ? mow_pkg::BK_OUT : mow_pkg::BK_MUL;
			mow_pkg::BK_OUT: if (!out_stall) state_d = mow_pkg::BK_IDLE;
			default: state_d = mow_pkg::BK_IDLE;
		endcase
	end

	assign out_valid = (state_q == mow_pkg::BK_OUT);
	assign vx_from_speed = res_q[0];
	assign vy_from_speed = res_q[1];
	assign yaw_from_speed = res_q[2];
	assign vx_from_ticks = res_q[3];
	assign vy_from_ticks = res_q[4];
	assign yaw_from_ticks = res_q[5];
	assign zero_interval = job_q.zero;
	assign clipped = clip_q;

endmodule
`default_nettype wire
